@@ src/ftu_pkg.sv @@
// ftu_pkg: types and constants for the float to unsigned converter
// no dependencies
package ftu_pkg;

   localparam int FLOAT_W = 32;
   localparam int MODE_W  = 3;
   localparam int VALUE_W = 63;
   localparam int STAT_W  = 2;

   localparam logic [30:0] FLT_EPS_MAG  = 31'h3400_0000;
   localparam logic [30:0] EXP_ALL_ONES = 31'h7F80_0000;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NEGATIVE  = 2'd1,
      ST_BAD_MODE  = 2'd2,
      ST_TOO_LARGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RM_NEAREST = 3'd0,
      RM_DOWN    = 3'd1,
      RM_UP      = 3'd2,
      RM_ZERO    = 3'd3
   } mode_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } result_type;

endpackage

@@ src/ftu_convert.sv @@
// ftu_convert: combinational binary32 to unsigned integer conversion with rounding
// depends on ftu_pkg
module ftu_convert
   import ftu_pkg::*;
(
   input  logic [FLOAT_W-1:0] float_bits,
   input  logic [MODE_W-1:0]  rounding_mode,
   output result_type         result
);

   logic        sign;
   logic [30:0] mag;
   logic [7:0]  expf;
   logic [7:0]  expe;
   logic [23:0] mant;
   logic [5:0]  lsh;
   logic [4:0]  rsh;
   logic [87:0] shifted_l;
   logic [48:0] wide;
   logic [23:0] ipart;
   logic [24:0] frac_part;
   logic [24:0] half;
   logic        up;
   logic [VALUE_W-1:0] sum;

   always_comb begin
      sign      = float_bits[31];
      mag       = float_bits[30:0];
      expf      = mag[30:23];
      expe      = (expf == 8'd0) ? 8'd1 : expf;
      mant      = (expf == 8'd0) ? {1'b0, mag[22:0]} : {1'b1, mag[22:0]};
      lsh       = (expe >= 8'd150) ? 6'(expe - 8'd150) : 6'd0;
      rsh       = (expe < 8'd150 && expe >= 8'd125) ? 5'(8'd150 - expe) : 5'd0;
      shifted_l = {64'd0, mant} << lsh;
      wide      = {mant, 25'd0} >> rsh;
      ipart     = wide[48:25];
      frac_part = wide[24:0];
      half      = 25'h100_0000;
      up        = 1'b0;
      result.value  = '0;
      result.status = ST_OK;
      sum       = '0;
      if (sign && mag >= FLT_EPS_MAG && mag <= EXP_ALL_ONES) begin
         result.status = ST_NEGATIVE;
      end else if (rounding_mode > MODE_W'(RM_ZERO)) begin
         result.status = ST_BAD_MODE;
      end else if (expf == 8'hFF) begin
         result.status = ST_TOO_LARGE;
      end else if (sign) begin
         if (mag != 31'd0 && rounding_mode == MODE_W'(RM_DOWN))
            result.status = ST_NEGATIVE;
      end else if (expe >= 8'd150) begin
         if (expe > 8'd189)
            result.status = ST_TOO_LARGE;
         else
            result.value = shifted_l[VALUE_W-1:0];
      end else if (expe < 8'd125) begin
         if (rounding_mode == MODE_W'(RM_UP) && mant != 24'd0)
            result.value = VALUE_W'(1);
      end else begin
         if (rounding_mode == MODE_W'(RM_NEAREST))
            up = (frac_part > half) || (frac_part == half && ipart[0]);
         else if (rounding_mode == MODE_W'(RM_UP))
            up = frac_part != 25'd0;
         sum = VALUE_W'(ipart) + VALUE_W'(up);
         result.value = sum;
      end
   end

endmodule

@@ src/float_to_unsigned_with_rounding.sv @@
// float_to_unsigned_with_rounding: top level, input register, converter, output skid
// depends on ftu_pkg and ftu_convert
//
// usage
//   req_ channel carries one binary32 value and a rounding mode per transfer
//   rsp_ channel returns the rounded integer and a status per transfer
//   requests go from the input register via the converter to the result register
//   throughput: one transfer per cycle while rsp_tready is high
//   the input register feeds the converter; the result register holds the
//   answer; a skid register keeps one extra result so req_tready depends
//   only on registered state
//   when the receiver stalls, results stay stable and at most three transfers
//   are held (input, result and skid registers); req_tready drops once the
//   skid register is full
//   reset (synchronous, active high) empties every stage; data in flight
//   is dropped
module float_to_unsigned_with_rounding
   import ftu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // float_bits[31:0], rounding_mode[34:32], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // converted_value[62:0], status[64:63], zero fill
);

   logic               in_vld_ff, in_vld_in;
   logic [FLOAT_W-1:0] in_bits_ff;
   logic [MODE_W-1:0]  in_mode_ff;
   result_type         conv;
   logic               out_vld_ff, out_vld_in;
   result_type         out_ff;
   logic               skid_vld_ff, skid_vld_in;
   result_type         skid_ff;
   logic               out_take;
   logic               in_move;

   ftu_convert u_convert (
      .float_bits    (in_bits_ff),
      .rounding_mode (in_mode_ff),
      .result        (conv)
   );

   assign req_tready = !skid_vld_ff;
   assign out_take   = rsp_tvalid && rsp_tready;
   assign in_move    = in_vld_ff && (!out_vld_ff || out_take || !skid_vld_ff);

   always_comb begin
      in_vld_in   = (req_tvalid && req_tready) || (in_vld_ff && !in_move);
      skid_vld_in = skid_vld_ff;
      out_vld_in  = out_vld_ff;
      if (out_take) begin
         out_vld_in  = skid_vld_ff || in_move;
         skid_vld_in = skid_vld_ff && in_move;
      end else if (in_move) begin
         if (out_vld_ff) skid_vld_in = 1'b1;
         else            out_vld_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_bits_ff <= req_tdata[31:0];
         in_mode_ff <= req_tdata[34:32];
      end
      if (out_take) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
            if (in_move) skid_ff <= conv;
         end else if (in_move) begin
            out_ff <= conv;
         end
      end else if (in_move) begin
         if (out_vld_ff) skid_ff <= conv;
         else            out_ff  <= conv;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_ff.status, out_ff.value};

endmodule
